// File: src/assert_macros.svh
// Assertion macros shared by the media queue RTL.
// Each macro wraps a concurrent assertion clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQKP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MQKP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mqkp_pkg.sv
// Package for the media queue with key-frame priority drop.
// Holds sizes, codes and the transfer and slot structs; depends on nothing.
package mqkp_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [PTR_W:0]   DEPTH_WIDE = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL   = OCC_W'(QUEUE_DEPTH);

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic KIND_VIDEO = 1'b0;
    localparam logic KIND_AUDIO = 1'b1;

    localparam logic [1:0] CODEC_H264 = 2'd0;
    localparam logic [1:0] CODEC_H265 = 2'd1;

    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_EVICTED = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_REJECT  = 3'd3;
    localparam logic [2:0] ST_POPPED  = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_VALID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_ID    = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic        media_kind;
        logic        key_frame;
        logic [1:0]  codec;
        logic [7:0]  monitor_id;
        logic [23:0] payload_size;
        logic [31:0] handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        out_kind;
        logic        out_key;
        logic [1:0]  out_codec;
        logic [23:0] out_size;
        logic [31:0] out_handle;
        logic [31:0] drop_total;
        logic [4:0]  fill_level;
    } rsp_t;

    typedef struct packed {
        logic        kind;
        logic        key;
        logic [1:0]  codec;
        logic [23:0] size;
        logic [31:0] handle;
    } slot_t;

    typedef struct packed {
        logic reject;
        logic latch;
        logic key_video;
    } adm_t;

endpackage

// File: src/media_queue_keyframe_priority_drop.sv
// Enqueue without eviction, reject, drop or empty dequeue gives its result in the cycle after it is
// taken. A dequeue reads the head slot into the read register and then loads its result in S_POP.
// A key frame on a full queue passes S_SCAN_RD and S_SCAN_CHK per slot examined plus S_MOVE and
// S_MOVE_WR per slot moved. One request is in work at a time; a new one is taken once its result is out.
// Reset clears control, pointers, monitor latch and drop counter; slot storage is not cleared.
module media_queue_keyframe_priority_drop
    import mqkp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_POP      = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_MOVE     = 3'd4;
    localparam logic [2:0] S_MOVE_WR  = 3'd5;

    function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] offs);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= DEPTH_WIDE)
        begin
            sum = sum - DEPTH_WIDE;
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    slot_t mem [QUEUE_DEPTH];

    logic [2:0]       state_reg,    state_next;
    logic [PTR_W-1:0] head_reg,     head_next;
    logic [PTR_W-1:0] tail_reg,     tail_next;
    logic [OCC_W-1:0] occ_reg,      occ_next;
    logic [PTR_W-1:0] idx_reg,      idx_next;
    logic [31:0]      drop_reg,     drop_next;
    logic             enable_reg,   enable_next;
    logic             pvalid_reg,   pvalid_next;
    logic [7:0]       pid_reg,      pid_next;
    logic [7:0]       chosen_reg,   chosen_next;
    logic             latched_reg,  latched_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg,      rsp_next;
    slot_t            entry_reg,    entry_next;
    slot_t            rd_data_reg;

    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    slot_t            wr_data;

    logic             out_free;
    logic             accept;
    logic             rsp_load;
    logic [2:0]       rsp_status;
    slot_t            rsp_entry;
    slot_t            new_entry;
    adm_t             adm;

    mqkp_admit u_admit (
        .req             (req),
        .enable          (enable_reg),
        .chosen_monitor  (chosen_reg),
        .monitor_latched (latched_reg),
        .adm             (adm)
    );

    assign new_entry = '{kind:   req.media_kind,
                         key:    req.key_frame,
                         codec:  req.codec,
                         size:   req.payload_size,
                         handle: req.handle};

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && out_free);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        drop_next      = drop_reg;
        enable_next    = enable_reg;
        pvalid_next    = pvalid_reg;
        pid_next       = pid_reg;
        chosen_next    = chosen_reg;
        latched_next   = latched_reg;
        entry_next     = entry_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        wr_data        = new_entry;
        rsp_load       = 1'b0;
        rsp_status     = ST_QUEUED;
        rsp_entry      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == OP_DEQUEUE)
                    begin
                        if (occ_reg == '0)
                        begin
                            rsp_load   = 1'b1;
                            rsp_status = ST_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_POP;
                        end
                    end
                    else
                    begin
                        if (adm.latch)
                        begin
                            chosen_next  = req.monitor_id;
                            latched_next = 1'b1;
                        end
                        if (adm.reject)
                        begin
                            rsp_load   = 1'b1;
                            rsp_status = ST_REJECT;
                        end
                        else if (occ_reg < OCC_FULL)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = tail_reg;
                            wr_data    = new_entry;
                            tail_next  = ptr_inc(tail_reg);
                            occ_next   = occ_reg + 1'b1;
                            rsp_load   = 1'b1;
                            rsp_status = ST_QUEUED;
                        end
                        else if (adm.key_video)
                        begin
                            entry_next = new_entry;
                            idx_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            drop_next  = (drop_reg != '1) ? drop_reg + 1'b1 : drop_reg;
                            rsp_load   = 1'b1;
                            rsp_status = ST_DROPPED;
                        end
                    end
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    rsp_status = ST_POPPED;
                    rsp_entry  = rd_data_reg;
                    head_next  = ptr_inc(head_reg);
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = slot_addr(head_reg, idx_reg);
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if ((rd_data_reg.kind == KIND_VIDEO) && !rd_data_reg.key)
                begin
                    state_next = S_MOVE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (out_free)
                    begin
                        drop_next  = (drop_reg != '1) ? drop_reg + 1'b1 : drop_reg;
                        rsp_load   = 1'b1;
                        rsp_status = ST_DROPPED;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_MOVE:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    if (out_free)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = slot_addr(head_reg, idx_reg);
                        wr_data    = entry_reg;
                        rsp_load   = 1'b1;
                        rsp_status = ST_EVICTED;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_addr(head_reg, idx_reg + 1'b1);
                    state_next = S_MOVE_WR;
                end
            end
            S_MOVE_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = slot_addr(head_reg, idx_reg);
                wr_data    = rd_data_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = S_MOVE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{status:     rsp_status,
                               out_kind:   rsp_entry.kind,
                               out_key:    rsp_entry.key,
                               out_codec:  rsp_entry.codec,
                               out_size:   rsp_entry.size,
                               out_handle: rsp_entry.handle,
                               drop_total: drop_next,
                               fill_level: 5'(occ_next)};
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:        enable_next = cfg_data[0];
                REG_PRIMARY_VALID: pvalid_next = cfg_data[0];
                REG_PRIMARY_ID:    pid_next    = cfg_data;
                default:           enable_next = enable_reg;
            endcase
            if (((cfg_index == REG_PRIMARY_VALID) || (cfg_index == REG_PRIMARY_ID))
                && pvalid_next)
            begin
                chosen_next  = pid_next;
                latched_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            drop_reg      <= '0;
            enable_reg    <= 1'b1;
            pvalid_reg    <= 1'b0;
            pid_reg       <= '0;
            chosen_reg    <= '0;
            latched_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            drop_reg      <= drop_next;
            enable_reg    <= enable_next;
            pvalid_reg    <= pvalid_next;
            pid_reg       <= pid_next;
            chosen_reg    <= chosen_next;
            latched_reg   <= latched_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`include "assert_macros.svh"

    `MQKP_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= OCC_FULL, "occupancy above queue depth")
    `MQKP_ASSERT_NOW(a_ptr_match, (occ_reg == '0) || (occ_reg == OCC_FULL),
        head_reg == tail_reg, "pointers disagree with occupancy")
    `MQKP_ASSERT_NOW(a_evict_full, (state_reg != S_IDLE) && (state_reg != S_POP),
        occ_reg == OCC_FULL, "eviction on a queue that is not full")
    `MQKP_ASSERT_NOW(a_pop_nonempty, state_reg == S_POP, occ_reg != '0, "pop of an empty queue")
    `MQKP_ASSERT_NEXT(a_drop_monotonic, 1'b1, drop_reg >= $past(drop_reg),
        "drop counter went down")

endmodule

// File: src/mqkp_admit.sv
// Admission check for one enqueue request: enable, size, monitor and codec tests.
// Depends on mqkp_pkg for the request and decision structs.
module mqkp_admit
    import mqkp_pkg::*;
(
    input  req_t       req,
    input  logic       enable,
    input  logic [7:0] chosen_monitor,
    input  logic       monitor_latched,
    output adm_t       adm
);

    logic       base_ok;
    logic       video;
    logic [7:0] sel_monitor;

    assign base_ok     = enable && (req.payload_size != 24'd0);
    assign video       = (req.media_kind == KIND_VIDEO);
    assign sel_monitor = monitor_latched ? chosen_monitor : req.monitor_id;

    // While none is latched, a base_ok video entry latches its monitor before the monitor and codec tests run.
    assign adm.latch     = base_ok && video && !monitor_latched;
    assign adm.reject    = !base_ok
                        || (video && ((sel_monitor != req.monitor_id)
                                      || (req.codec > CODEC_H265)));
    assign adm.key_video = video && req.key_frame;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the media descriptor queue with key-frame priority drop.
// Depends on mqkp_pkg and the media_queue_keyframe_priority_drop RTL; nothing else.
module tb;
    import mqkp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0] CODEC_OTHER_A = 2'd2;
    localparam logic [1:0] CODEC_OTHER_B = 2'd3;
    localparam logic [31:0] DROP_MAX = 32'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slot_t       shadow_slots[$];
    rsp_t        expected_outcomes[$];
    logic        en_reg = 1'b1;
    logic        primary_valid_reg = 1'b0;
    logic [7:0]  primary_id_reg = 8'h00;
    logic [7:0]  sel_monitor = 8'h00;
    logic        monitor_held = 1'b0;
    logic [31:0] drop_count = 32'h0;
    int          mismatch_count = 0;
    int          idle_pct = 0;
    int          stall_left = 0;
    int          cycle_count = 0;

    media_queue_keyframe_priority_drop dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            stall_left = $urandom_range(1, 15);
        if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none, actual %h", $time, rsp);
                mismatch_count++;
            end
            else
            begin
                want = expected_outcomes[0];
                expected_outcomes.delete(0);
                compare_field("status", 32'(want.status), 32'(rsp.status));
                compare_field("out_kind", 32'(want.out_kind), 32'(rsp.out_kind));
                compare_field("out_key", 32'(want.out_key), 32'(rsp.out_key));
                compare_field("out_codec", 32'(want.out_codec), 32'(rsp.out_codec));
                compare_field("out_size", 32'(want.out_size), 32'(rsp.out_size));
                compare_field("out_handle", want.out_handle, rsp.out_handle);
                compare_field("drop_total", want.drop_total, rsp.drop_total);
                compare_field("fill_level", 32'(want.fill_level), 32'(rsp.fill_level));
            end
        end
    end

    function automatic logic [2:0] admit_entry(input slot_t entry, input logic [7:0] mon);
        int victim = -1;
        if (!en_reg || entry.size == 24'h0)
            return ST_REJECT;
        if (entry.kind == KIND_VIDEO)
        begin
            if (!monitor_held)
            begin
                sel_monitor = mon;
                monitor_held = 1'b1;
            end
            if (sel_monitor != mon || entry.codec > CODEC_H265)
                return ST_REJECT;
        end
        if (shadow_slots.size() >= QUEUE_DEPTH)
        begin
            if (entry.kind == KIND_VIDEO && entry.key)
                for (int i = 0; i < shadow_slots.size() && victim < 0; i++)
                    if (shadow_slots[i].kind == KIND_VIDEO && !shadow_slots[i].key)
                        victim = i;
            if (victim < 0)
            begin
                if (drop_count != DROP_MAX)
                    drop_count++;
                return ST_DROPPED;
            end
            shadow_slots.delete(victim);
            shadow_slots.insert(shadow_slots.size(), entry);
            return ST_EVICTED;
        end
        shadow_slots.insert(shadow_slots.size(), entry);
        return ST_QUEUED;
    endfunction

    task automatic predict_outcome(input req_t r);
        rsp_t  e;
        slot_t entry;
        e = '0;
        entry.kind = r.media_kind;
        entry.key = r.key_frame;
        entry.codec = r.codec;
        entry.size = r.payload_size;
        entry.handle = r.handle;
        if (r.opcode == OP_DEQUEUE)
        begin
            if (shadow_slots.size() == 0)
                e.status = ST_EMPTY;
            else
            begin
                entry = shadow_slots[0];
                shadow_slots.delete(0);
                e.status = ST_POPPED;
                e.out_kind = entry.kind;
                e.out_key = entry.key;
                e.out_codec = entry.codec;
                e.out_size = entry.size;
                e.out_handle = entry.handle;
            end
        end
        else
            e.status = admit_entry(entry, r.monitor_id);
        e.drop_total = drop_count;
        e.fill_level = 5'(shadow_slots.size());
        expected_outcomes.insert(expected_outcomes.size(), e);
    endtask

    function automatic req_t make_req(input logic op, input logic kind, input logic key,
                                      input logic [1:0] codec, input logic [7:0] mon,
                                      input logic [23:0] size, input logic [31:0] handle);
        req_t r;
        r.opcode = op;
        r.media_kind = kind;
        r.key_frame = key;
        r.codec = codec;
        r.monitor_id = mon;
        r.payload_size = size;
        r.handle = handle;
        return r;
    endfunction

    function automatic req_t random_request(input int deq_pct);
        req_t r;
        int   pick;
        r.opcode = ($urandom_range(0, 99) < deq_pct) ? OP_DEQUEUE : OP_ENQUEUE;
        r.media_kind = $urandom_range(0, 1) ? KIND_AUDIO : KIND_VIDEO;
        r.key_frame = 1'($urandom);
        if ($urandom_range(0, 9) == 0)
            r.codec = 2'($urandom);
        else
            r.codec = $urandom_range(0, 1) ? CODEC_H265 : CODEC_H264;
        r.monitor_id = (monitor_held && $urandom_range(0, 9) != 0) ? sel_monitor : 8'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.payload_size = 24'h0;
        else if (pick == 1)
            r.payload_size = 24'hFF_FFFF;
        else
            r.payload_size = 24'($urandom_range(1, 24'hFF_FFFF));
        r.handle = $urandom;
        return r;
    endfunction

    task automatic send_item(input req_t r);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        predict_outcome(r);
    endtask

    task automatic settle_idle(input int extra);
        req_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE:        en_reg = value[0];
            REG_PRIMARY_VALID: primary_valid_reg = value[0];
            REG_PRIMARY_ID:    primary_id_reg = value;
            default:           ;
        endcase
        if ((idx == REG_PRIMARY_VALID || idx == REG_PRIMARY_ID) && primary_valid_reg)
        begin
            sel_monitor = primary_id_reg;
            monitor_held = 1'b1;
        end
        @(posedge clk);
    endtask

    // The first video entry has a bad codec, yet it still selects its monitor.
    task automatic test_admission();
        send_item(make_req(OP_DEQUEUE, KIND_VIDEO, 1'b0, CODEC_H264, 8'h00, 24'h0, 32'h0));
        send_item(make_req(OP_ENQUEUE, KIND_AUDIO, 1'b0, CODEC_H264, 8'h00, 24'h0, 32'h1));
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b0, CODEC_OTHER_B, 8'h5A, 24'd100,
                           32'h2));
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b0, CODEC_H264, 8'hA5, 24'd100, 32'h3));
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b0, CODEC_OTHER_A, 8'h5A, 24'd100,
                           32'h4));
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b0, CODEC_H264, 8'h5A, 24'd1, 32'h0));
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b1, CODEC_H265, 8'h5A, 24'hFF_FFFF,
                           32'hFFFF_FFFF));
        send_item(make_req(OP_ENQUEUE, KIND_AUDIO, 1'b1, CODEC_OTHER_B, 8'hFF, 24'hFF_FFFF,
                           32'hFFFF_FFFF));
        repeat (4)
            send_item(make_req(OP_DEQUEUE, KIND_AUDIO, 1'b1, CODEC_OTHER_B, 8'hFF,
                               24'hFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (i == 4)
                send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b0, CODEC_H264, 8'h5A,
                                   24'd64, 32'(i)));
            else
                send_item(make_req(OP_ENQUEUE, KIND_AUDIO, 1'b0, CODEC_H264, 8'h00,
                                   24'd32 + 24'(i), 32'(i)));
        send_item(make_req(OP_ENQUEUE, KIND_AUDIO, 1'b0, CODEC_H265, 8'h00, 24'd7, 32'h100));
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b1, CODEC_H264, 8'h5A, 24'd9, 32'h101));
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b1, CODEC_H265, 8'h5A, 24'd9, 32'h102));
    endtask

    task automatic test_config_registers();
        settle_idle(SETTLE_CYCLES);
        write_register(REG_ENABLE, 8'hFE);
        send_item(make_req(OP_ENQUEUE, KIND_AUDIO, 1'b0, CODEC_H264, 8'h00, 24'd5, 32'h200));
        send_item(make_req(OP_DEQUEUE, KIND_AUDIO, 1'b0, CODEC_H264, 8'h00, 24'd5, 32'h201));
        settle_idle(SETTLE_CYCLES);
        write_register(REG_ENABLE, 8'h01);
        write_register(REG_PRIMARY_ID, 8'h33);
        write_register(REG_PRIMARY_VALID, 8'h01);
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b0, CODEC_H264, 8'h33, 24'd11, 32'h202));
        settle_idle(SETTLE_CYCLES);
        write_register(REG_PRIMARY_VALID, 8'h00);
        write_register(REG_PRIMARY_ID, 8'hFF);
        write_register(REG_UNUSED, 8'hFF);
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b1, CODEC_H265, 8'h33, 24'd12, 32'h203));
        send_item(make_req(OP_ENQUEUE, KIND_VIDEO, 1'b0, CODEC_H264, 8'h5A, 24'd13, 32'h204));
    endtask

    task automatic test_random_traffic();
        int deq_pct;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_idle(SETTLE_CYCLES);
            idle_pct = 0;
            if (phase == 0 || phase == PHASES - 1)
                write_register(REG_ENABLE, {7'($urandom), 1'b1});
            else
                write_register(REG_ENABLE, {7'($urandom), 1'($urandom_range(0, 5) != 0)});
            if (phase == 0)
                write_register(REG_PRIMARY_ID, 8'h00);
            else if (phase == 1)
                write_register(REG_PRIMARY_ID, 8'hFF);
            else
                write_register(REG_PRIMARY_ID, 8'($urandom));
            write_register(REG_PRIMARY_VALID, {7'($urandom), 1'($urandom)});
            deq_pct = (phase % 3 == 0) ? 25 : ((phase % 3 == 1) ? 45 : 65);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 25 == 0)
                    idle_pct = (phase == PHASES - 1 || n % 50 == 0) ? 0 : 8;
                if (phase == 3 && n == 50)
                    settle_idle(0);
                send_item(random_request(deq_pct));
            end
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_admission();
        test_full_queue();
        test_config_registers();
        test_random_traffic();
        settle_idle(4 * QUEUE_DEPTH + 16);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
